>>> sv/rpn_pkg.sv
// Package for the postfix expression evaluator: widths, character codes,
// status codes, command and state types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2,
		ST_DIVZ = 3'd3, ST_NUMOVF = 3'd4, ST_BADCH = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2,
		OP_MUL = 3'd3, OP_DIV = 3'd4, OP_BAD = 3'd5
	} op_t;

	// One command from the front part: an optional push of a finished
	// number, then an optional operation, then an optional report.
	typedef struct packed {
		logic        push;
		logic [31:0] number;
		logic        numovf;
		op_t         op;
		logic        last;
	} cmd_t;

	typedef enum logic [2:0] {
		BE_IDLE, BE_PUSH, BE_OP, BE_MUL, BE_DIV, BE_DIVFIX, BE_REPORT
	} be_state_t;
endpackage
`default_nettype wire

>>> sv/rpn_stream_if.sv
// Valid/ready channel carrying one payload item.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rpn_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/rpn_expression_evaluator_top.sv
// Top level of the postfix expression evaluator.
// Depends on rpn_pkg, rpn_stream_if, rpn_front, rpn_queue, rpn_back.
//
// The in channel carries one character item {last_char, char_code}; the out
// channel carries one result item {status, value} for each item marked last.
// Digits are absorbed by the front part at one item a cycle while the queue
// has room. Every other character becomes a command in a four-entry queue;
// the back part takes each command through its push and operation steps, a
// multiply or divide also through its iteration steps (one bit a cycle in
// a shared shift register datapath) and a fix-up step, and a last item
// through a report step that loads the result register. Reset clears the
// stack count, errors, queue and result valid; stack contents are not
// cleared. While the receiver stalls, the result register holds, the back
// part waits at its next report step, the queue fills and input ready falls.
`timescale 1ns / 1ps
`default_nettype none
module rpn_expression_evaluator_top import rpn_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	rpn_stream_if.sink in_ch,
	rpn_stream_if.source out_ch
);
	logic f_valid, f_ready, q_valid, q_ready;
	cmd_t f_cmd, q_cmd;
	logic [31:0] val;
	logic [2:0] stat;

	rpn_front u_front (
		.clk, .arst_n,
		.char_code(in_ch.data[7:0]), .last_char(in_ch.data[8]),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
	);

	rpn_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd)
	);

	rpn_back u_back (
		.clk, .arst_n,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_value(val), .out_status(stat)
	);

	assign out_ch.data = {stat, val};
endmodule
`default_nettype wire

>>> sv/rpn_front.sv
// Front part: builds numbers from digits and turns characters into commands.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpn_front import rpn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [7:0] char_code,
	input  wire logic last_char,
	input  wire logic in_valid,
	output logic in_ready,
	output logic cmd_valid,
	output cmd_t cmd,
	input  wire logic cmd_ready
);
	logic [31:0] acc_q;
	logic in_num_q;
	logic ovf_q;
	logic is_digit;
	logic [35:0] nxt;
	logic ovf_now;

	assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign nxt = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + {32'd0, char_code[3:0]};
	assign ovf_now = nxt > 36'd2147483647;

	// Classify the character into a command.
	always_comb begin
		cmd = '0;
		cmd.number = acc_q;
		cmd.last = last_char;
		if (is_digit) begin
			cmd.numovf = ovf_now && !ovf_q;
			if (last_char && !ovf_now && !ovf_q) begin
				cmd.push = 1'b1;
				cmd.number = nxt[31:0];
			end
		end else begin
			cmd.push = in_num_q && !ovf_q;
			unique case (char_code)
				CH_PLUS:  cmd.op = OP_ADD;
				CH_MINUS: cmd.op = OP_SUB;
				CH_STAR:  cmd.op = OP_MUL;
				CH_SLASH: cmd.op = OP_DIV;
				CH_SPACE: cmd.op = OP_NONE;
				default:  cmd.op = OP_BAD;
			endcase
		end
	end

	// Digits that build a number cause no command unless they are last or first overflow it.
	assign cmd_valid = in_valid && (!is_digit || last_char || (ovf_now && !ovf_q));
	assign in_ready = cmd_ready;

	// Number accumulator; after an overflow the expression is dead until last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			in_num_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			if (last_char) begin
				acc_q <= '0;
				in_num_q <= 1'b0;
				ovf_q <= 1'b0;
			end else if (is_digit) begin
				if (ovf_now || ovf_q) begin
					ovf_q <= 1'b1;
				end else begin
					acc_q <= nxt[31:0];
					in_num_q <= 1'b1;
				end
			end else begin
				acc_q <= '0;
				in_num_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> sv/rpn_queue.sv
// Small command queue between front and back parts.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpn_queue import rpn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic wr_ready,
	input  wire cmd_t wr_cmd,
	output logic rd_valid,
	input  wire logic rd_ready,
	output cmd_t rd_cmd
);
	cmd_t mem_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wp_q, rp_q;
	logic [QP_W:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (QP_W+1)'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_cmd = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_cmd;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QP_W+1)'(wr) - (QP_W+1)'(rd);
		end
	end
endmodule
`default_nettype wire

>>> sv/rpn_back.sv
// Back part: value stack, iterative multiply and divide, result register.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rpn_back import rpn_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic cmd_ready,
	input  wire cmd_t cmd,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [31:0] out_value,
	output logic [2:0] out_status
);
	logic [31:0] stack_q [STACK_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	status_t err_q;
	be_state_t st_q, st_d;
	cmd_t cmd_q;
	logic [31:0] a_q, b_q, acc_q, rem_q;
	logic [5:0] it_q;
	logic neg_q;
	logic full, has2;
	logic [32:0] trial;
	logic [31:0] res_d;
	logic [31:0] addsub;
	logic res_we, busy_out;

	assign full = cnt_q == CNT_W'(STACK_DEPTH);
	assign has2 = cnt_q >= CNT_W'(2);
	assign trial = {rem_q, acc_q[31]} - {1'b0, b_q};
	assign busy_out = out_valid && !out_ready;
	assign addsub = (cmd_q.op == OP_ADD) ? a_q + b_q : a_q - b_q;

	// Next state.
	always_comb begin
		st_d = st_q;
		cmd_ready = 1'b0;
		unique case (st_q)
			BE_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) st_d = BE_PUSH;
			end
			BE_PUSH: st_d = BE_OP;
			BE_OP: begin
				if (err_q == ST_OK && has2 && cmd_q.op == OP_MUL) st_d = BE_MUL;
				else if (err_q == ST_OK && has2 && cmd_q.op == OP_DIV && b_q != '0)
					st_d = BE_DIV;
				else if (cmd_q.last) st_d = BE_REPORT;
				else st_d = BE_IDLE;
			end
			BE_MUL, BE_DIV: if (it_q == 6'd31) st_d = BE_DIVFIX;
			BE_DIVFIX: st_d = cmd_q.last ? BE_REPORT : BE_IDLE;
			BE_REPORT: if (!busy_out) st_d = BE_IDLE;
			default: st_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BE_IDLE;
		else st_q <= st_d;
	end

	// Result value of a finished operation.
	always_comb begin
		res_we = 1'b0;
		res_d = acc_q;
		if (st_q == BE_DIVFIX) begin
			res_we = 1'b1;
			if (cmd_q.op == OP_DIV) res_d = neg_q ? (32'd0 - acc_q) : acc_q;
		end
	end

	// Stack count, error register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= ST_OK;
			out_valid <= 1'b0;
			out_value <= '0;
			out_status <= '0;
		end else begin
			if (st_q == BE_REPORT && !busy_out) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				BE_IDLE: ;
				BE_PUSH: begin
					if (cmd_q.numovf && err_q == ST_OK) err_q <= ST_NUMOVF;
					else if (cmd_q.push && err_q == ST_OK) begin
						if (full) err_q <= ST_OVER;
						else cnt_q <= cnt_q + 1'b1;
					end
				end
				BE_OP: begin
					if (err_q == ST_OK) begin
						priority case (1'b1)
							cmd_q.op == OP_NONE: ;
							cmd_q.op == OP_BAD: err_q <= ST_BADCH;
							!has2: err_q <= ST_UNDER;
							cmd_q.op == OP_ADD: cnt_q <= cnt_q - 1'b1;
							cmd_q.op == OP_SUB: cnt_q <= cnt_q - 1'b1;
							cmd_q.op == OP_DIV && b_q == '0: err_q <= ST_DIVZ;
							default: ;
						endcase
					end
				end
				BE_DIVFIX: begin
					if (res_we) cnt_q <= cnt_q - 1'b1;
				end
				BE_REPORT: begin
					if (!busy_out) begin
						if (err_q == ST_OK && cnt_q == '0) out_status <= ST_UNDER;
						else out_status <= err_q;
						out_value <= (err_q == ST_OK && cnt_q != '0) ? b_q : 32'd0;
						cnt_q <= '0;
						err_q <= ST_OK;
					end
				end
				default: ;
			endcase
		end
	end

	// Stack writes, operand fetch, shift-add multiply and restoring divide.
	always_ff @(posedge clk) begin
		unique case (st_q)
			BE_IDLE: if (cmd_valid) cmd_q <= cmd;
			BE_PUSH: begin
				if (cmd_q.push && err_q == ST_OK && !cmd_q.numovf && !full) begin
					stack_q[SP_W'(cnt_q)] <= cmd_q.number;
					b_q <= cmd_q.number;
					a_q <= stack_q[SP_W'(cnt_q - 1'b1)];
				end else begin
					b_q <= stack_q[SP_W'(cnt_q - 1'b1)];
					a_q <= stack_q[SP_W'(cnt_q - CNT_W'(2))];
				end
			end
			BE_OP: begin
				it_q <= '0;
				if (cmd_q.op == OP_MUL) begin
					acc_q <= '0;
					rem_q <= a_q;
				end else if (cmd_q.op == OP_DIV) begin
					neg_q <= a_q[31] ^ b_q[31];
					acc_q <= a_q[31] ? 32'd0 - a_q : a_q;
					b_q <= b_q[31] ? 32'd0 - b_q : b_q;
					rem_q <= '0;
				end else if (err_q == ST_OK && has2
						&& (cmd_q.op == OP_ADD || cmd_q.op == OP_SUB)) begin
					// The new top is kept in b_q for a report on the last item.
					stack_q[SP_W'(cnt_q - CNT_W'(2))] <= addsub;
					b_q <= addsub;
				end
			end
			BE_MUL: begin
				it_q <= it_q + 1'b1;
				if (b_q[0]) acc_q <= acc_q + rem_q;
				rem_q <= {rem_q[30:0], 1'b0};
				b_q <= {1'b0, b_q[31:1]};
			end
			BE_DIV: begin
				it_q <= it_q + 1'b1;
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					acc_q <= {acc_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], acc_q[31]};
					acc_q <= {acc_q[30:0], 1'b0};
				end
			end
			BE_DIVFIX: begin
				if (res_we) stack_q[SP_W'(cnt_q - CNT_W'(2))] <= res_d;
				b_q <= res_d;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> sv/rpn_checker.sv
// Port checker for the evaluator top level, bound to it.
// Depends on rpn_expression_evaluator_top and its rpn_stream_if ports.
`timescale 1ns / 1ps
`default_nettype none
module rpn_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [34:0] out_data
);
	// A stalled result item holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// Status is always a defined code.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data[34:32] <= 3'd5)
		else $error("undefined status");
	// An error result reports value zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[34:32] != 3'd0 |-> out_data[31:0] == 32'd0)
		else $error("nonzero value with error");
endmodule

bind rpn_expression_evaluator_top rpn_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
